/* hdl/lrupr_pkg.sv */
// lrupr_pkg: types and constants shared by the lru page replacement unit
// holds the request and response structs, default parameters and reset values
// no dependencies
package lrupr_pkg;

   localparam int MAX_FRAMES_DEFAULT = 16;
   localparam int PAGE_BITS_DEFAULT  = 20;

   localparam int PAGE_W   = 20;
   localparam int FRAME_W  = 4;
   localparam int STAMP_W  = 32;
   localparam int FAULT_W  = 32;
   localparam int CSR_W    = 5;

   localparam logic [CSR_W-1:0] FRAMES_RESET = 5'd3;

   typedef struct packed {
      logic [PAGE_W-1:0] page_number;
      logic              last_reference;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [FRAME_W-1:0] frame_index;
      logic               evicted_valid;
      logic [PAGE_W-1:0]  evicted_page;
      logic [FAULT_W-1:0] fault_total;
      logic               final_res;
   } rsp_type;

endpackage

/* hdl/lru_page_replacement_unit.sv */
// lru_page_replacement_unit: lru page replacement with last-use stamps, uses lrupr_pkg
// one item at a time, busy stays high meanwhile;
// the frame scan reads one frame per cycle from the page and stamp memories
// reset (synchronous, active high) empties the table, zeroes both counters, sets the
// frame count register to 3; the receiver cannot stall, each result shows for one cycle
module lru_page_replacement_unit #(
   parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEFAULT,
   parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  lrupr_pkg::req_type          req_payload,
   output logic                        rsp_valid,
   output lrupr_pkg::rsp_type          rsp_payload,
   input  logic                        csr_write_enable,
   input  logic [lrupr_pkg::CSR_W-1:0] csr_write_data
);
   import lrupr_pkg::*;

   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   // control and configuration registers
   logic [1:0]           state_ff, state_in;
   logic [CSR_W-1:0]     frames_ff;
   logic [MAX_FRAMES-1:0] valid_ff, valid_in;
   logic [STAMP_W-1:0]   use_ctr_ff, use_ctr_in;
   logic [FAULT_W-1:0]   fault_ctr_ff, fault_ctr_in;
   logic                 ev_valid_ff, ev_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // item and scan registers
   logic [PAGE_BITS-1:0] page_ff;
   logic                 last_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]     ev_idx_ff;
   logic                 hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]     hit_slot_ff, hit_slot_in;
   logic                 empty_found_ff, empty_found_in;
   logic [IDX_W-1:0]     empty_slot_ff, empty_slot_in;
   logic [STAMP_W-1:0]   oldest_ff, oldest_in;
   logic [IDX_W-1:0]     old_slot_ff, old_slot_in;
   logic [PAGE_BITS-1:0] old_page_ff, old_page_in;
   rsp_type              rsp_ff, rsp_in;

   // frame memories and their registered read data
   logic [PAGE_BITS-1:0] page_mem [MAX_FRAMES];
   logic [STAMP_W-1:0]   stamp_mem [MAX_FRAMES];
   logic [PAGE_BITS-1:0] page_q;
   logic [STAMP_W-1:0]   stamp_q;

   logic                 accept;
   logic [CNT_W-1:0]     count_clamped;
   logic                 scan_last;
   logic [IDX_W-1:0]     slot;
   logic                 mem_we;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // clamp the frame count register into 1..MAX_FRAMES
   always_comb begin
      if (frames_ff == '0) begin
         count_clamped = CNT_W'(1);
      end else if (int'(frames_ff) > MAX_FRAMES) begin
         count_clamped = CNT_W'(MAX_FRAMES);
      end else begin
         count_clamped = CNT_W'(frames_ff);
      end
   end

   assign scan_last = (CNT_W'(rd_idx_ff) == CNT_W'(count_ff - CNT_W'(1)));

   // chosen frame: hit, else first empty, else oldest stamp
   always_comb begin
      priority if (hit_found_ff) begin
         slot = hit_slot_ff;
      end else if (empty_found_ff) begin
         slot = empty_slot_ff;
      end else begin
         slot = old_slot_ff;
      end
   end

   assign mem_we = (state_ff == ST_COMMIT);

   // sequencer, scan accumulators and commit
   always_comb begin
      state_in       = state_ff;
      valid_in       = valid_ff;
      use_ctr_in     = use_ctr_ff;
      fault_ctr_in   = fault_ctr_ff;
      rd_idx_in      = rd_idx_ff;
      ev_valid_in    = (state_ff == ST_SCAN);
      rsp_valid_in   = 1'b0;
      hit_found_in   = hit_found_ff;
      hit_slot_in    = hit_slot_ff;
      empty_found_in = empty_found_ff;
      empty_slot_in  = empty_slot_ff;
      oldest_in      = oldest_ff;
      old_slot_in    = old_slot_ff;
      old_page_in    = old_page_ff;
      rsp_in         = rsp_ff;

      // evaluate the frame read in the previous cycle
      if (ev_valid_ff) begin
         if (!hit_found_ff && valid_ff[ev_idx_ff] && (page_q == page_ff)) begin
            hit_found_in = 1'b1;
            hit_slot_in  = ev_idx_ff;
         end
         if (!empty_found_ff && !valid_ff[ev_idx_ff]) begin
            empty_found_in = 1'b1;
            empty_slot_in  = ev_idx_ff;
         end
         if ((ev_idx_ff == '0) || (stamp_q < oldest_ff)) begin
            oldest_in   = stamp_q;
            old_slot_in = ev_idx_ff;
            old_page_in = page_q;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in       = ST_SCAN;
               rd_idx_in      = '0;
               hit_found_in   = 1'b0;
               empty_found_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (!hit_found_ff && (fault_ctr_ff != '1)) begin
               fault_ctr_in = fault_ctr_ff + FAULT_W'(1);
            end
            valid_in[slot] = 1'b1;
            use_ctr_in     = use_ctr_ff + STAMP_W'(1);

            rsp_in.hit           = hit_found_ff;
            rsp_in.frame_index   = FRAME_W'(slot);
            rsp_in.evicted_valid = !hit_found_ff && !empty_found_ff;
            rsp_in.evicted_page  = (!hit_found_ff && !empty_found_ff) ?
                                   PAGE_W'(old_page_ff) : '0;
            rsp_in.fault_total   = fault_ctr_in;
            rsp_in.final_res     = last_ff;

            // end of string empties the table
            if (last_ff) begin
               valid_in     = '0;
               use_ctr_in   = '0;
               fault_ctr_in = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frames_ff    <= FRAMES_RESET;
         valid_ff     <= '0;
         use_ctr_ff   <= '0;
         fault_ctr_ff <= '0;
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         use_ctr_ff   <= use_ctr_in;
         fault_ctr_ff <= fault_ctr_in;
         ev_valid_ff  <= ev_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            frames_ff <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff  <= PAGE_BITS'(req_payload.page_number);
         last_ff  <= req_payload.last_reference;
         count_ff <= count_clamped;
      end
      rd_idx_ff      <= rd_idx_in;
      ev_idx_ff      <= rd_idx_ff;
      hit_found_ff   <= hit_found_in;
      hit_slot_ff    <= hit_slot_in;
      empty_found_ff <= empty_found_in;
      empty_slot_ff  <= empty_slot_in;
      oldest_ff      <= oldest_in;
      old_slot_ff    <= old_slot_in;
      old_page_ff    <= old_page_in;
      rsp_ff         <= rsp_in;
   end

   // frame memories: one write port at commit, one registered read port for the scan
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stamp_mem[slot] <= use_ctr_ff;
         if (!hit_found_ff) begin
            page_mem[slot] <= page_ff;
         end
      end
      page_q  <= page_mem[rd_idx_ff];
      stamp_q <= stamp_mem[rd_idx_ff];
   end

   // checks
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after an accepted transfer");

   a_commit_strobe : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) |=> rsp_valid)
      else $error("commit without result strobe");

   a_single_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_scan_range : assert property (@(posedge clock) disable iff (reset)
      ev_valid_ff |-> (CNT_W'(ev_idx_ff) < count_ff))
      else $error("scan evaluated a frame beyond the active count");

   a_string_clear : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.final_res) |-> (valid_ff == '0) && (fault_ctr_ff == '0))
      else $error("table not emptied after the final reference");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking testbench for the lru page replacement unit
// drives page references and frame-count writes, predicts each lookup in lru order
// depends on lrupr_pkg and lru_page_replacement_unit
module tb;
   import lrupr_pkg::*;

   localparam int NUM_FRAMES    = MAX_FRAMES_DEFAULT;
   localparam int RANDOM_REFS   = 700;
   localparam int STALL_LIMIT   = 2000;
   localparam int TAIL_CYCLES   = 25;
   localparam int QUIET_FIRST   = 250;
   localparam int QUIET_LAST    = 400;
   localparam int NUM_DIRECTED  = 19;

   // one directed row: optional frame-count write, the reference, optional typed outcome
   typedef struct packed {
      bit               set_frames;
      logic [CSR_W-1:0] frames;
      req_type          access;
      bit               typed;
      rsp_type          want;
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      // fresh table under the reset frame count of three
      '{1'b0, 5'd0,  '{20'h00000, 1'b0}, 1'b1, '{1'b0, 4'd0, 1'b0, 20'h0, 32'd1, 1'b0}},
      '{1'b0, 5'd0,  '{20'hFFFFF, 1'b0}, 1'b1, '{1'b0, 4'd1, 1'b0, 20'h0, 32'd2, 1'b0}},
      '{1'b0, 5'd0,  '{20'h00000, 1'b0}, 1'b1, '{1'b1, 4'd0, 1'b0, 20'h0, 32'd2, 1'b0}},
      '{1'b0, 5'd0,  '{20'h00005, 1'b0}, 1'b0, '0},
      // table full, least recently used frame goes
      '{1'b0, 5'd0,  '{20'h00007, 1'b0}, 1'b0, '0},
      '{1'b0, 5'd0,  '{20'h00007, 1'b1}, 1'b0, '0},
      // end of string empties the table
      '{1'b0, 5'd0,  '{20'h00007, 1'b0}, 1'b1, '{1'b0, 4'd0, 1'b0, 20'h0, 32'd1, 1'b0}},
      // single frame, every miss evicts
      '{1'b1, 5'd1,  '{20'h0000A, 1'b0}, 1'b0, '0},
      '{1'b0, 5'd1,  '{20'h0000B, 1'b0}, 1'b0, '0},
      // zero frames behaves as one
      '{1'b1, 5'd0,  '{20'h0000B, 1'b0}, 1'b0, '0},
      // out-of-range count clamps to the full table
      '{1'b1, 5'd31, '{20'h0000C, 1'b0}, 1'b0, '0},
      '{1'b0, 5'd31, '{20'h0000D, 1'b0}, 1'b0, '0},
      '{1'b0, 5'd31, '{20'h80000, 1'b0}, 1'b0, '0},
      '{1'b0, 5'd31, '{20'h7FFFF, 1'b0}, 1'b0, '0},
      // shrink mid-string, upper frames ignored but kept
      '{1'b1, 5'd2,  '{20'h0000D, 1'b0}, 1'b0, '0},
      '{1'b1, 5'd16, '{20'h80000, 1'b0}, 1'b0, '0},
      '{1'b0, 5'd16, '{20'h12345, 1'b1}, 1'b0, '0},
      '{1'b0, 5'd16, '{20'h12345, 1'b0}, 1'b1, '{1'b0, 4'd0, 1'b0, 20'h0, 32'd1, 1'b0}},
      '{1'b0, 5'd16, '{20'h12345, 1'b1}, 1'b1, '{1'b1, 4'd0, 1'b0, 20'h0, 32'd1, 1'b1}}
   };

   logic             clock            = 1'b0;
   logic             reset            = 1'b1;
   logic             start            = 1'b0;
   logic             busy;
   req_type          req_payload      = '0;
   logic             rsp_valid;
   rsp_type          rsp_payload;
   logic             csr_write_enable = 1'b0;
   logic [CSR_W-1:0] csr_write_data   = '0;

   // predictor state
   logic [PAGE_W-1:0]  page_table  [NUM_FRAMES];
   bit                 valid_table [NUM_FRAMES];
   logic [STAMP_W-1:0] stamp_table [NUM_FRAMES];
   logic [STAMP_W-1:0] use_count;
   logic [FAULT_W-1:0] fault_count;
   logic [CSR_W-1:0]   frames_reg;

   rsp_type predicted_outcomes [$];
   int      error_count  = 0;
   int      stall_cycles = 0;
   bit      idle_enabled = 1'b1;

   lru_page_replacement_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // back to an empty table, both counters cleared
   function automatic void clear_table();
      int i;
      for (i = 0; i < NUM_FRAMES; i++) begin
         page_table[i]  = '0;
         valid_table[i] = 1'b0;
         stamp_table[i] = '0;
      end
      use_count   = '0;
      fault_count = '0;
   endfunction

   function automatic int active_frames();
      if (frames_reg == 0) return 1;
      if (frames_reg > NUM_FRAMES) return NUM_FRAMES;
      return int'(frames_reg);
   endfunction

   // lookup with lru replacement, updates the predictor table
   function automatic rsp_type lru_lookup(input req_type access);
      int                count;
      int                i;
      int                slot;
      bit                found;
      bit                empty_found;
      bit                evict;
      logic [PAGE_W-1:0] victim;
      rsp_type           outcome;
      count       = active_frames();
      slot        = 0;
      found       = 1'b0;
      empty_found = 1'b0;
      evict       = 1'b0;
      victim      = '0;
      for (i = 0; i < count && !found; i++) begin
         if (valid_table[i] && page_table[i] == access.page_number) begin
            found = 1'b1;
            slot  = i;
         end
      end
      if (!found) begin
         for (i = 0; i < count && !empty_found; i++) begin
            if (!valid_table[i]) begin
               empty_found = 1'b1;
               slot        = i;
            end
         end
         // oldest stamp among the active frames, ties to the lowest index
         if (!empty_found) begin
            slot = 0;
            for (i = 1; i < count; i++) begin
               if (stamp_table[i] < stamp_table[slot]) slot = i;
            end
            evict  = 1'b1;
            victim = page_table[slot];
         end
         page_table[slot]  = access.page_number;
         valid_table[slot] = 1'b1;
         if (fault_count != '1) fault_count = fault_count + 1'b1;
      end
      stamp_table[slot] = use_count;
      use_count         = use_count + 1'b1;
      outcome.hit           = found;
      outcome.frame_index   = slot[FRAME_W-1:0];
      outcome.evicted_valid = evict;
      outcome.evicted_page  = victim;
      outcome.fault_total   = fault_count;
      outcome.final_res     = access.last_reference;
      if (access.last_reference) clear_table();
      return outcome;
   endfunction

   // random frame count, mostly small, with the clamped extremes now and then
   function automatic logic [CSR_W-1:0] pick_frames();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) return CSR_W'($urandom_range(4, 1));
      if (roll < 80) return CSR_W'($urandom_range(16, 5));
      if (roll < 90) return '0;
      return CSR_W'($urandom_range(31, 17));
   endfunction

   // one reference transfer, with random idle cycles ahead of it
   task automatic issue_access(input req_type access, input bit typed, input rsp_type want);
      rsp_type predicted;
      while (idle_enabled && $urandom_range(99) < 21) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= access;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = lru_lookup(access);
      predicted_outcomes.push_back(typed ? want : predicted);
   endtask

   // frame-count write once the unit has drained
   task automatic write_frames(input logic [CSR_W-1:0] value);
      start <= 1'b0;
      @(posedge clock);
      while (predicted_outcomes.size() != 0 || busy) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      frames_reg = value;
   endtask

   // result checking against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (predicted_outcomes.size() == 0) begin
            $error("result transfer with no reference outstanding");
            error_count++;
         end else begin
            want = predicted_outcomes.pop_front();
            if (rsp_payload.hit !== want.hit) begin
               $error("hit: expected %0d, actual %0d", want.hit, rsp_payload.hit);
               error_count++;
            end
            if (rsp_payload.frame_index !== want.frame_index) begin
               $error("frame_index: expected %0d, actual %0d",
                      want.frame_index, rsp_payload.frame_index);
               error_count++;
            end
            if (rsp_payload.evicted_valid !== want.evicted_valid) begin
               $error("evicted_valid: expected %0d, actual %0d",
                      want.evicted_valid, rsp_payload.evicted_valid);
               error_count++;
            end
            if (rsp_payload.evicted_page !== want.evicted_page) begin
               $error("evicted_page: expected %h, actual %h",
                      want.evicted_page, rsp_payload.evicted_page);
               error_count++;
            end
            if (rsp_payload.fault_total !== want.fault_total) begin
               $error("fault_total: expected %0d, actual %0d",
                      want.fault_total, rsp_payload.fault_total);
               error_count++;
            end
            if (rsp_payload.final_res !== want.final_res) begin
               $error("final_res: expected %0d, actual %0d",
                      want.final_res, rsp_payload.final_res);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write_enable) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      stim_row_type      row;
      req_type           access;
      logic [PAGE_W-1:0] page_pool [$];
      int                sent;
      int                refs_left;
      int                pool_size;
      int                n;
      clear_table();
      frames_reg = FRAMES_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (n = 0; n < NUM_DIRECTED; n++) begin
         row = DIRECTED_ROWS[n];
         if (row.set_frames) write_frames(row.frames);
         issue_access(row.access, row.typed, row.want);
      end

      // random reference strings drawn from a small working set, plus stray pages
      sent      = 0;
      refs_left = 0;
      while (sent < RANDOM_REFS) begin
         if (refs_left == 0) begin
            if ($urandom_range(99) < 30) write_frames(pick_frames());
            refs_left = $urandom_range(80, 1);
            pool_size = $urandom_range(2 * active_frames() + 2, 1);
            page_pool.delete();
            repeat (pool_size) page_pool.push_back(PAGE_W'($urandom));
         end else if ($urandom_range(99) < 3) begin
            write_frames(pick_frames());
         end
         idle_enabled = !(sent >= QUIET_FIRST && sent < QUIET_LAST);
         if ($urandom_range(99) < 88)
            access.page_number = page_pool[$urandom_range(page_pool.size() - 1)];
         else
            access.page_number = PAGE_W'($urandom);
         access.last_reference = (refs_left == 1);
         issue_access(access, 1'b0, '0);
         refs_left--;
         sent++;
      end
      start <= 1'b0;

      // drain, then allow for the longest scan
      while (predicted_outcomes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
